/* sv/sfla_pkg.sv */
// shared types and constants for the slab free list allocator
// no dependencies; imported by slab_free_list_allocator
`default_nettype none

package sfla_pkg;

	localparam int OFFSET_W   = 21;
	localparam int DIVIDEND_W = 20;
	localparam int SIZE_W     = 13;
	localparam int CAP_W      = 9;
	localparam int STATUS_W   = 3;
	localparam int IDX_OUT_W  = 8;
	localparam int SLOT_OFF_W = 20;
	localparam int FREE_W     = 9;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 13;
	localparam int STEP_W     = 5;
	localparam int DIV_STEPS  = DIVIDEND_W;

	localparam logic [SIZE_W-1:0] MIN_SIZE     = 13'd8;
	localparam logic [SIZE_W-1:0] OBJ_SIZE_RST = 13'd8;
	localparam logic [CAP_W-1:0]  CAP_RST      = 9'd256;

	localparam logic [CFG_IDX_W-1:0] REG_OBJECT_SIZE   = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_SLOT_CAPACITY = 1'b1;

	localparam logic OP_ALLOC = 1'b0;
	localparam logic OP_FREE  = 1'b1;

	typedef enum logic [2:0] {
		ST_SWEEP,
		ST_IDLE,
		ST_ARD,
		ST_DIV,
		ST_CHECK,
		ST_MUL,
		ST_DONE
	} state_t;

	typedef enum logic [STATUS_W-1:0] {
		STS_ALLOC     = 3'd0,
		STS_FREED     = 3'd1,
		STS_EXHAUSTED = 3'd2,
		STS_RANGE     = 3'd3,
		STS_FULL      = 3'd4
	} status_t;

endpackage

`default_nettype wire

/* sv/sfla_ram.sv */
// generic single write port ram with registered read
// no dependencies; holds the next-index links of the free list
`default_nettype none

module sfla_ram #(
	parameter int WIDTH = 9,
	parameter int DEPTH = 256
) (
	input  wire logic                                       clk,
	input  wire logic                                       we,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire logic [WIDTH-1:0]                           wdata,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic      [WIDTH-1:0]                           rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

/* sv/slab_free_list_allocator.sv */
// alloc reads the list head, then multiplies; free divides, checks, multiplies;
// exhausted or negative offset go straight to the result; out of range or full
// skip the multiply; one item at a time: the next beat can be taken in the same
// cycle that the result appears; the work runs on the shared 20-bit adder
// (20 divide steps, 20 multiply steps); after reset and any register write a
// pass over all SLOTS entries rebuilds the link ram; no beat is taken during it
`default_nettype none

module slab_free_list_allocator import sfla_pkg::*; #(
	parameter int SLOTS           = 256,
	parameter int MAX_OBJECT_SIZE = 4096
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       cfg_we,
	input  wire logic [CFG_IDX_W-1:0]       cfg_index,
	input  wire logic [CFG_DATA_W-1:0]      cfg_data,
	input  wire logic                       in_valid,
	output logic                            in_ready,
	input  wire logic                       op,
	input  wire logic signed [OFFSET_W-1:0] byte_offset,
	output logic                            out_valid,
	input  wire logic                       out_ready,
	output logic      [STATUS_W-1:0]        status,
	output logic      [IDX_OUT_W-1:0]       slot_index,
	output logic      [SLOT_OFF_W-1:0]      slot_offset,
	output logic      [FREE_W-1:0]          free_slots
);

	localparam int ADDR_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int LINK_W = $clog2(SLOTS + 1);
	localparam logic [LINK_W-1:0] END_MARK  = LINK_W'(SLOTS);
	localparam logic [LINK_W-1:0] LAST_SLOT = LINK_W'(SLOTS - 1);
	localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(DIV_STEPS - 1);

	state_t state_q, state_d;

	logic [SIZE_W-1:0]     object_size_q;
	logic [CAP_W-1:0]      slot_capacity_q;
	logic [LINK_W-1:0]     sweep_q;
	logic [LINK_W-1:0]     head_q;
	logic [LINK_W-1:0]     total_q;
	logic [STEP_W-1:0]     step_q;
	logic [DIVIDEND_W-1:0] work_q;
	logic [SIZE_W-1:0]     rem_q;
	logic [SLOT_OFF_W-1:0] acc_q;
	logic [ADDR_W-1:0]     idx_q;
	status_t               sts_q;
	logic                  out_valid_q;
	status_t               out_status_q;
	logic [IDX_OUT_W-1:0]  out_index_q;
	logic [SLOT_OFF_W-1:0] out_offset_q;
	logic [FREE_W-1:0]     out_free_q;

	logic [SIZE_W-1:0]     eff_size;
	logic [CAP_W-1:0]      cap_nz;
	logic [LINK_W-1:0]     eff_cap;
	logic [LINK_W-1:0]     sweep_nxt;
	logic [LINK_W-1:0]     sweep_link;
	logic                  range_bad;
	logic                  list_full;
	logic                  out_load;

	logic [SLOT_OFF_W-1:0] add_a;
	logic [SLOT_OFF_W-1:0] add_b;
	logic                  add_cin;
	logic [SLOT_OFF_W:0]   add_sum;

	logic                  ram_we;
	logic [ADDR_W-1:0]     ram_waddr;
	logic [LINK_W-1:0]     ram_wdata;
	logic [LINK_W-1:0]     ram_rdata;

	// effective size and capacity from the registers
	always_comb begin
		eff_size = object_size_q;
		if (object_size_q < MIN_SIZE) begin
			eff_size = MIN_SIZE;
		end else if (32'(object_size_q) > MAX_OBJECT_SIZE) begin
			eff_size = SIZE_W'(MAX_OBJECT_SIZE);
		end
		cap_nz  = (slot_capacity_q == '0) ? CAP_W'(1) : slot_capacity_q;
		eff_cap = (32'(cap_nz) > SLOTS) ? END_MARK : LINK_W'(cap_nz);
	end

	assign sweep_nxt  = sweep_q + LINK_W'(1);
	assign sweep_link = (sweep_nxt < eff_cap) ? sweep_nxt : END_MARK;
	assign range_bad  = 32'(work_q) >= 32'(eff_cap);
	assign list_full  = total_q >= eff_cap;
	assign out_load   = !out_valid_q || out_ready;

	// shared adder: restoring divide step or shift-add multiply step
	always_comb begin
		if (state_q == ST_DIV) begin
			add_a   = SLOT_OFF_W'({rem_q, work_q[DIVIDEND_W-1]});
			add_b   = ~SLOT_OFF_W'(eff_size);
			add_cin = 1'b1;
		end else begin
			add_a   = {acc_q[SLOT_OFF_W-2:0], 1'b0};
			add_b   = work_q[DIVIDEND_W-1] ? SLOT_OFF_W'(eff_size) : '0;
			add_cin = 1'b0;
		end
		add_sum = {1'b0, add_a} + {1'b0, add_b} + (SLOT_OFF_W + 1)'(add_cin);
	end

	// next state
	always_comb begin
		state_d = state_q;
		if (cfg_we) begin
			state_d = ST_SWEEP;
		end else begin
			unique case (state_q)
				ST_SWEEP: begin
					if (sweep_q == LAST_SLOT) state_d = ST_IDLE;
				end
				ST_IDLE: begin
					if (in_valid) begin
						if (op == OP_FREE) begin
							state_d = byte_offset[OFFSET_W-1] ? ST_DONE : ST_DIV;
						end else begin
							state_d = (head_q == END_MARK) ? ST_DONE : ST_ARD;
						end
					end
				end
				ST_ARD: state_d = ST_MUL;
				ST_DIV: begin
					if (step_q == STEP_LAST) state_d = ST_CHECK;
				end
				ST_CHECK: state_d = (range_bad || list_full) ? ST_DONE : ST_MUL;
				ST_MUL: begin
					if (step_q == STEP_LAST) state_d = ST_DONE;
				end
				ST_DONE: begin
					if (out_load) state_d = ST_IDLE;
				end
				default: state_d = ST_SWEEP;
			endcase
		end
	end

	// outputs of the sequencer
	always_comb begin
		in_ready  = 1'b0;
		ram_we    = 1'b0;
		ram_waddr = sweep_q[ADDR_W-1:0];
		ram_wdata = sweep_link;
		unique case (state_q)
			ST_SWEEP: ram_we = 1'b1;
			ST_IDLE:  in_ready = 1'b1;
			ST_CHECK: begin
				if (!range_bad && !list_full) begin
					ram_we    = 1'b1;
					ram_waddr = work_q[ADDR_W-1:0];
					ram_wdata = head_q;
				end
			end
			default: ;
		endcase
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= ST_SWEEP;
			object_size_q   <= OBJ_SIZE_RST;
			slot_capacity_q <= CAP_RST;
			sweep_q         <= '0;
			head_q          <= '0;
			total_q         <= '0;
			step_q          <= '0;
			out_valid_q     <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				unique case (cfg_index)
					REG_OBJECT_SIZE:   object_size_q   <= cfg_data;
					REG_SLOT_CAPACITY: slot_capacity_q <= cfg_data[CAP_W-1:0];
					default: ;
				endcase
			end
			if (cfg_we) begin
				sweep_q <= '0;
			end else if (state_q == ST_SWEEP) begin
				sweep_q <= sweep_nxt;
			end
			if (!cfg_we && state_q == ST_SWEEP && sweep_q == LAST_SLOT) begin
				head_q  <= '0;
				total_q <= eff_cap;
			end else if (state_q == ST_ARD) begin
				head_q <= ram_rdata;
				if (total_q != '0) total_q <= total_q - LINK_W'(1);
			end else if (state_q == ST_CHECK && !range_bad && !list_full) begin
				head_q  <= LINK_W'(work_q);
				total_q <= total_q + LINK_W'(1);
			end
			if ((state_q == ST_DIV || state_q == ST_MUL) && step_q != STEP_LAST) begin
				step_q <= step_q + STEP_W'(1);
			end else begin
				step_q <= '0;
			end
			if (state_q == ST_DONE && out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					work_q <= byte_offset[DIVIDEND_W-1:0];
					rem_q  <= '0;
					acc_q  <= '0;
					idx_q  <= '0;
					if (op == OP_FREE) begin
						sts_q <= byte_offset[OFFSET_W-1] ? STS_RANGE : STS_FREED;
					end else begin
						sts_q <= (head_q == END_MARK) ? STS_EXHAUSTED : STS_ALLOC;
					end
				end
			end
			ST_ARD: begin
				work_q <= DIVIDEND_W'(head_q);
				idx_q  <= head_q[ADDR_W-1:0];
				acc_q  <= '0;
			end
			ST_DIV: begin
				// carry out set means the trial subtract did not borrow
				rem_q  <= add_sum[SLOT_OFF_W] ? add_sum[SIZE_W-1:0] : add_a[SIZE_W-1:0];
				work_q <= {work_q[DIVIDEND_W-2:0], add_sum[SLOT_OFF_W]};
			end
			ST_CHECK: begin
				if (range_bad) begin
					sts_q <= STS_RANGE;
				end else if (list_full) begin
					sts_q <= STS_FULL;
				end else begin
					idx_q <= work_q[ADDR_W-1:0];
					acc_q <= '0;
				end
			end
			ST_MUL: begin
				acc_q  <= add_sum[SLOT_OFF_W-1:0];
				work_q <= {work_q[DIVIDEND_W-2:0], 1'b0};
			end
			ST_DONE: begin
				if (out_load) begin
					out_status_q <= sts_q;
					out_index_q  <= IDX_OUT_W'(idx_q);
					out_offset_q <= acc_q;
					out_free_q   <= FREE_W'(total_q);
				end
			end
			default: ;
		endcase
	end

	sfla_ram #(
		.WIDTH(LINK_W),
		.DEPTH(SLOTS)
	) u_links (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(head_q[ADDR_W-1:0]),
		.rdata(ram_rdata)
	);

	assign out_valid   = out_valid_q;
	assign status      = out_status_q;
	assign slot_index  = out_index_q;
	assign slot_offset = out_offset_q;
	assign free_slots  = out_free_q;

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("input taken while an item is in progress");

	a_head_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_SWEEP) |-> (head_q <= END_MARK))
		else $error("list head beyond end mark");

	a_total_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_SWEEP) |-> (total_q <= eff_cap))
		else $error("free count above capacity");

	a_error_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && (status == STS_EXHAUSTED || status == STS_RANGE || status == STS_FULL))
		|-> (slot_index == '0 && slot_offset == '0))
		else $error("error beat carries a slot");

endmodule

`default_nettype wire
